// ===== rtl/core/lms_system_identifier_core_macros.svh =====
// Assertion macros for the LMS system identifier core.
// Included by the top level; expects clk and rst in scope.
`ifndef LMS_SYSTEM_IDENTIFIER_CORE_MACROS_SVH
`define LMS_SYSTEM_IDENTIFIER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LMS_SID_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lms_sid: implication check failed");
`define LMS_SID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lms_sid: next-cycle check failed");
`else
`define LMS_SID_ASSERT_IMPL(label, ante, cons)
`define LMS_SID_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/lms_sid_pkg.sv =====
// Shared types and constants for the LMS system identifier core.
// No dependencies.
`default_nettype none

package lms_sid_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TAP_IDX_W = 6;
  localparam int WEIGHT_W  = 32;
  localparam int STEP_W    = 16;
  localparam int SHIFT_W   = 6;

  localparam int FIX_FRAC = 15;
  localparam int W_FRAC   = 30;

  // shared multiplier: signed A x signed B
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = STEP_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // low part of the step*error product, unsigned
  localparam int KLO_W = 24;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = 32'sh8000_0000;

  localparam logic MODE_LOAD_TAP = 1'b0;
  localparam logic MODE_SAMPLE   = 1'b1;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_SELECT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_MULT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_SHIFT    = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_MULT_RST  = 16'd28;
  localparam logic [SHIFT_W-1:0] STEP_SHIFT_RST = 6'd18;

  typedef struct packed {
    logic               output_select;
    logic [STEP_W-1:0]  step_mult;
    logic [SHIFT_W-1:0] step_shift;
  } lms_sid_cfg_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } lms_sid_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIX,
    ST_ADAPT,
    ST_ERR,
    ST_KMUL,
    ST_KCAP,
    ST_UPD,
    ST_DONE
  } lms_sid_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lms_sid_req_if.sv =====
// Request channel: one tap load or one noise sample per request.
// Depends on lms_sid_pkg.
`default_nettype none

interface lms_sid_req_if;
  import lms_sid_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [SAMPLE_W-1:0] tap_value;

  modport source (output valid, mode, sample_in, tap_index, tap_value, input ready);
  modport sink   (input valid, mode, sample_in, tap_index, tap_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lms_sid_res_if.sv =====
// Result channel: selected filter output and error.
// Depends on lms_sid_pkg.
`default_nettype none

interface lms_sid_res_if;
  import lms_sid_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic signed [SAMPLE_W-1:0] error_sample;

  modport source (output valid, out_sample, error_sample, input ready);
  modport sink   (input valid, out_sample, error_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lms_system_identifier_core.sv =====
// Top level of the LMS system identifier: APB registers and the LMS engine.
// Depends on lms_sid_pkg, both channel interfaces, lms_sid_regs, lms_sid_engine.
//
//   port    | kind          | carries
//   --------+---------------+--------------------------------------------
//   req     | valid/ready   | mode, sample_in, tap_index, tap_value
//   result  | valid/ready   | out_sample, error_sample
//   p*      | APB, no wait  | output_select, step_mult, step_shift
//
// Tap load request: written to the tap memory on acceptance; req.ready stays high.
// Sample request: the one shared multiplier does the fixed MAC, the adaptive MAC,
// the step*error product and two products per weight update. After reset a
// clearing pass zeroes the memories; req.ready stays low.
// A finished result waits in the output register while new requests enter.
`default_nettype none
`include "lms_system_identifier_core_macros.svh"

module lms_system_identifier_core #(
  parameter int FIXED_TAPS = 64,
  parameter int ADAPT_TAPS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lms_sid_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lms_sid_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lms_sid_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready,
  lms_sid_req_if.sink                        req,
  lms_sid_res_if.source                      result
);
  import lms_sid_pkg::*;

  lms_sid_cfg_t  cfg;
  lms_sid_stat_t stat;
  logic          req_acc;

  assign req_acc = req.valid && req.ready;

  lms_sid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lms_sid_engine #(
    .FIXED_TAPS (FIXED_TAPS),
    .ADAPT_TAPS (ADAPT_TAPS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (req),
    .res  (result),
    .stat (stat)
  );

  `LMS_SID_ASSERT_IMPL(a_clear_blocks_req, stat.clearing, !req.ready)
  `LMS_SID_ASSERT_NEXT(a_sample_goes_busy, req_acc && req.mode == MODE_SAMPLE, !req.ready)
  `LMS_SID_ASSERT_NEXT(a_tap_load_one_cycle, req_acc && req.mode == MODE_LOAD_TAP, req.ready)
  `LMS_SID_ASSERT_IMPL(a_result_from_work, $rose(result.valid), $past(stat.busy))
endmodule

`default_nettype wire

// ===== rtl/core/lms_sid_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on lms_sid_pkg.
`default_nettype none

module lms_sid_mul (
  input  logic                                   clk,
  input  logic signed [lms_sid_pkg::MUL_A_W-1:0] a,
  input  logic signed [lms_sid_pkg::MUL_B_W-1:0] b,
  output logic signed [lms_sid_pkg::MUL_P_W-1:0] p
);
  import lms_sid_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

`default_nettype wire

// ===== rtl/core/lms_sid_regs.sv =====
// APB configuration registers: output select, step multiplier, step shift.
// Depends on lms_sid_pkg.
`default_nettype none

module lms_sid_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lms_sid_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lms_sid_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lms_sid_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                 pready,
  output lms_sid_pkg::lms_sid_cfg_t            cfg
);
  import lms_sid_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[REG_IDX_W+1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_select <= 1'b0;
      cfg.step_mult     <= STEP_MULT_RST;
      cfg.step_shift    <= STEP_SHIFT_RST;
    end else if (wr) begin
      case (idx)
        REG_OUTPUT_SELECT: cfg.output_select <= pwdata[0];
        REG_STEP_MULT:     cfg.step_mult     <= pwdata[STEP_W-1:0];
        REG_STEP_SHIFT:    cfg.step_shift    <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OUTPUT_SELECT: prdata = {{(APB_DATA_W-1){1'b0}}, cfg.output_select};
      REG_STEP_MULT:     prdata = {{(APB_DATA_W-STEP_W){1'b0}}, cfg.step_mult};
      REG_STEP_SHIFT:    prdata = {{(APB_DATA_W-SHIFT_W){1'b0}}, cfg.step_shift};
      default:           prdata = '0;
    endcase
  end
endmodule

`default_nettype wire

// ===== rtl/core/lms_sid_engine.sv =====
// Sequencer, sample/tap/weight memories and result register.
// Depends on lms_sid_pkg, lms_sid_req_if, lms_sid_res_if, lms_sid_mul.
`default_nettype none

module lms_sid_engine #(
  parameter int FIXED_TAPS = 64,
  parameter int ADAPT_TAPS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lms_sid_pkg::lms_sid_cfg_t  cfg,
  lms_sid_req_if.sink                req,
  lms_sid_res_if.source              res,
  output lms_sid_pkg::lms_sid_stat_t stat
);
  import lms_sid_pkg::*;

  localparam int HIST_LEN = (FIXED_TAPS > ADAPT_TAPS) ? FIXED_TAPS : ADAPT_TAPS;
  localparam int H_W      = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int F_W      = (FIXED_TAPS > 1) ? $clog2(FIXED_TAPS) : 1;
  localparam int A_W      = (ADAPT_TAPS > 1) ? $clog2(ADAPT_TAPS) : 1;
  localparam int CNT_W    = $clog2(HIST_LEN + 1);
  localparam int FACC_W   = 2 * SAMPLE_W + $clog2(FIXED_TAPS + 1);
  localparam int AACC_W   = WEIGHT_W + SAMPLE_W + $clog2(ADAPT_TAPS + 1);
  localparam int FO_W     = FACC_W - FIX_FRAC;
  localparam int AO_W     = AACC_W - W_FRAC;
  localparam int ERR_W    = ((FO_W > AO_W) ? FO_W : AO_W) + 1;
  localparam int K_W      = ERR_W + MUL_B_W;
  localparam int SUM_W    = K_W + SAMPLE_W;
  localparam int WS_W     = SUM_W + 1;

  lms_sid_state_t state, state_next;

  logic [CNT_W-1:0] cnt;
  logic [H_W-1:0]   ha, p, ha_dec, p_inc;
  logic             ph;
  logic             iss, mac_done, upd_done, req_acc, is_sample, res_free;

  logic signed [SAMPLE_W-1:0] x_q, tap_q;
  logic signed [WEIGHT_W-1:0] w_q;

  logic signed [SAMPLE_W-1:0] hist_mem [HIST_LEN];
  logic signed [SAMPLE_W-1:0] tap_mem  [FIXED_TAPS];
  logic signed [WEIGHT_W-1:0] w_mem    [ADAPT_TAPS];

  logic                       h_we, t_we, w_we;
  logic [H_W-1:0]             h_wa;
  logic [F_W-1:0]             t_wa;
  logic [A_W-1:0]             w_wa;
  logic signed [SAMPLE_W-1:0] h_wd, t_wd;
  logic signed [WEIGHT_W-1:0] w_wd;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_q;

  logic                      v1, v2;
  logic signed [FACC_W-1:0]  acc_fix, fo;
  logic signed [AACC_W-1:0]  acc_ad, ao;
  logic signed [ERR_W-1:0]   err, err_next;
  logic signed [K_W-1:0]     k;
  logic [SAMPLE_W-1:0]       sel_q;

  logic                       u1_v, u1_ph, u2_v, u2_ph, v3, v4;
  logic [A_W-1:0]             i1, i2, i3, i4;
  logic signed [WEIGHT_W-1:0] w2, w3, w4;
  logic signed [MUL_P_W-1:0]  lo;
  logic signed [SUM_W-1:0]    sum3, d4;
  logic signed [WS_W-1:0]     ws;
  logic signed [WEIGHT_W-1:0] w_sat;

  logic                res_valid;
  logic [SAMPLE_W-1:0] res_out, res_err;

  assign req.ready        = (state == ST_IDLE);
  assign req_acc          = req.valid && req.ready;
  assign is_sample        = (req.mode == MODE_SAMPLE);
  assign res.valid        = res_valid;
  assign res.out_sample   = res_out;
  assign res.error_sample = res_err;
  assign res_free         = !res_valid || res.ready;
  assign stat.clearing    = (state == ST_CLEAR);
  assign stat.busy        = (state != ST_IDLE) && (state != ST_CLEAR);

  assign ha_dec = (ha == '0) ? H_W'(HIST_LEN - 1) : ha - 1'b1;
  assign p_inc  = (p == H_W'(HIST_LEN - 1)) ? '0 : p + 1'b1;

  always_comb begin
    case (state)
      ST_FIX:          iss = (cnt < CNT_W'(FIXED_TAPS));
      ST_ADAPT, ST_UPD: iss = (cnt < CNT_W'(ADAPT_TAPS));
      default:         iss = 1'b0;
    endcase
  end

  assign mac_done = !iss && !v1 && !v2;
  assign upd_done = !iss && !u1_v && !u2_v && !v3 && !v4;

  assign fo       = acc_fix >>> FIX_FRAC;
  assign ao       = acc_ad >>> W_FRAC;
  assign err_next = ERR_W'(fo) - ERR_W'(ao);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (cnt == CNT_W'(HIST_LEN - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (req_acc && is_sample) state_next = ST_FIX;
      ST_FIX:   if (mac_done) state_next = ST_ADAPT;
      ST_ADAPT: if (mac_done) state_next = ST_ERR;
      ST_ERR:   state_next = ST_KMUL;
      ST_KMUL:  state_next = ST_KCAP;
      ST_KCAP:  state_next = ST_UPD;
      ST_UPD:   if (upd_done) state_next = ST_DONE;
      ST_DONE:  if (res_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer counters and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ha        <= '0;
      p         <= '0;
      ph        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      u1_v      <= 1'b0;
      u2_v      <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1   <= iss && ((state == ST_FIX) || (state == ST_ADAPT));
      v2   <= v1;
      u1_v <= iss && (state == ST_UPD);
      u2_v <= u1_v;
      v3   <= u2_v && u2_ph;
      v4   <= v3;
      if (state == ST_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cnt <= (cnt == CNT_W'(HIST_LEN - 1)) ? '0 : cnt + 1'b1;
        end
        ST_IDLE: begin
          if (req_acc && is_sample) begin
            cnt <= '0;
            ha  <= p;
          end
        end
        ST_FIX, ST_ADAPT: begin
          if (iss) begin
            cnt <= cnt + 1'b1;
            ha  <= ha_dec;
          end else if (mac_done) begin
            cnt <= '0;
            ha  <= p;
          end
        end
        ST_KCAP: begin
          cnt <= '0;
          ha  <= p;
          ph  <= 1'b0;
        end
        ST_UPD: begin
          if (iss) begin
            ph <= ~ph;
            if (ph) begin
              cnt <= cnt + 1'b1;
              ha  <= ha_dec;
            end
          end
          if (upd_done) p <= p_inc;
        end
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_b = MUL_B_W'(x_q);
    case (state)
      ST_FIX:  mul_a = MUL_A_W'(tap_q);
      ST_ADAPT: mul_a = MUL_A_W'(w_q);
      ST_KMUL: begin
        mul_a = MUL_A_W'(err);
        mul_b = $signed({1'b0, cfg.step_mult});
      end
      ST_UPD: begin
        if (u1_ph) mul_a = MUL_A_W'($signed(k[K_W-1:KLO_W]));
        else       mul_a = MUL_A_W'($signed({1'b0, k[KLO_W-1:0]}));
      end
      default: mul_a = MUL_A_W'(w_q);
    endcase
  end

  lms_sid_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_q)
  );

  // weight update tail: add and saturate
  assign ws = WS_W'(w4) + WS_W'(d4);
  always_comb begin
    if (ws > WS_W'(W_MAX))      w_sat = W_MAX;
    else if (ws < WS_W'(W_MIN)) w_sat = W_MIN;
    else                        w_sat = WEIGHT_W'(ws);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_acc && is_sample) begin
      acc_fix <= '0;
    end else if (v2 && state == ST_FIX) begin
      acc_fix <= acc_fix + FACC_W'(mul_q);
    end
    if (state == ST_FIX && mac_done) begin
      acc_ad <= '0;
    end else if (v2 && state == ST_ADAPT) begin
      acc_ad <= acc_ad + AACC_W'(mul_q);
    end
    if (state == ST_ERR) begin
      err   <= err_next;
      sel_q <= cfg.output_select ? fo[SAMPLE_W-1:0] : ao[SAMPLE_W-1:0];
    end
    if (state == ST_KCAP) k <= K_W'(mul_q);
    if (state == ST_DONE && res_free) begin
      res_out <= sel_q;
      res_err <= err[SAMPLE_W-1:0];
    end
    u1_ph <= ph;
    i1    <= cnt[A_W-1:0];
    u2_ph <= u1_ph;
    w2    <= w_q;
    i2    <= i1;
    if (u2_v && !u2_ph) lo <= mul_q;
    sum3 <= (SUM_W'(mul_q) <<< KLO_W) + SUM_W'(lo);
    w3   <= w2;
    i3   <= i2;
    d4   <= sum3 >>> cfg.step_shift;
    w4   <= w3;
    i4   <= i3;
  end

  // memory write ports
  always_comb begin
    h_we = 1'b0;
    h_wa = cnt[H_W-1:0];
    h_wd = '0;
    t_we = 1'b0;
    t_wa = cnt[F_W-1:0];
    t_wd = '0;
    w_we = 1'b0;
    w_wa = cnt[A_W-1:0];
    w_wd = '0;
    case (state)
      ST_CLEAR: begin
        h_we = 1'b1;
        t_we = (cnt < CNT_W'(FIXED_TAPS));
        w_we = (cnt < CNT_W'(ADAPT_TAPS));
      end
      ST_IDLE: begin
        if (req_acc && is_sample) begin
          h_we = 1'b1;
          h_wa = p;
          h_wd = req.sample_in;
        end else if (req_acc) begin
          t_we = (32'(req.tap_index) < 32'(FIXED_TAPS));
          t_wa = F_W'(req.tap_index);
          t_wd = req.tap_value;
        end
      end
      ST_UPD: begin
        w_we = v4;
        w_wa = i4;
        w_wd = w_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_wa] <= h_wd;
    x_q <= hist_mem[ha];
  end

  always_ff @(posedge clk) begin
    if (t_we) tap_mem[t_wa] <= t_wd;
    tap_q <= tap_mem[cnt[F_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    w_q <= w_mem[cnt[A_W-1:0]];
  end
endmodule

`default_nettype wire
